@@ src/tdt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared constants, codes and types of the task dependency tracker.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int TABLE_ENTRIES     = 1024;
  localparam int READERS_PER_ENTRY = 8;
  localparam int MAX_READS         = 8;
  localparam int TASK_ID_BITS      = 16;

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int RD_W      = (READERS_PER_ENTRY > 1) ? $clog2(READERS_PER_ENTRY) : 1;
  localparam int RC_W      = $clog2(READERS_PER_ENTRY + 1);
  localparam int PI_W      = (MAX_READS > 1) ? $clog2(MAX_READS) : 1;
  localparam int PC_W      = $clog2(MAX_READS + 1);
  localparam int FOUND_CAP = MAX_READS + 1 + READERS_PER_ENTRY;
  localparam int FI_W      = $clog2(FOUND_CAP);
  localparam int FC_W      = $clog2(FOUND_CAP + 1);
  localparam int PROD_W    = IDX_W + 16;
  localparam int ADDR_W    = 48;

  localparam logic [63:0] HASH_K = 64'h45d9f3b;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_OVF   = 3'd2;
  localparam logic [2:0] ST_READS = 3'd3;
  localparam logic [2:0] ST_IDS   = 3'd4;

  typedef struct packed {
    logic                    used;
    logic [ADDR_W-1:0]       key;
    logic                    wvalid;
    logic [TASK_ID_BITS-1:0] wtask;
    logic [RC_W-1:0]         rcount;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

@@ src/tdt_in_if.sv @@
// ----------------------------------------------------------------------------
// tdt_in_if
// Operand item channel: opcode and block address.
// ----------------------------------------------------------------------------
interface tdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [47:0] address;
  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

@@ src/tdt_out_if.sv @@
// ----------------------------------------------------------------------------
// tdt_out_if
// Dependency result channel.
// ----------------------------------------------------------------------------
interface tdt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] task_id;
  logic [15:0] pred_task;
  logic        is_dep;
  logic [4:0]  dep_total;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, output task_id, output pred_task, output is_dep,
                  output dep_total, output status, output last, input ready);
  modport sink   (input valid, input task_id, input pred_task, input is_dep,
                  input dep_total, input status, input last, output ready);
endinterface

@@ src/tdt_ram.sv @@
// ----------------------------------------------------------------------------
// tdt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/tdt_hash.sv @@
// ----------------------------------------------------------------------------
// tdt_hash
// Home slot of an address: shift, xor, multiply, xor, one register stage.
// ----------------------------------------------------------------------------
module tdt_hash (
  input  logic                      clk,
  input  logic [47:0]               addr,
  output logic [tdt_pkg::IDX_W-1:0] slot
);
  import tdt_pkg::*;

  logic [44:0]       h0;
  logic [44:0]       h1;
  logic [PROD_W-1:0] prod;

  // only the low bits of the product reach the slot index
  assign h0 = addr[47:3];
  assign h1 = h0 ^ (h0 >> 16);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(h1[PROD_W-1:0] * PROD_W'(HASH_K));
  end

  assign slot = prod[IDX_W-1:0] ^ prod[IDX_W+15:16];
endmodule

@@ src/task_dependency_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// task_dependency_tracker_unit
// steps: a read hashes its address, probes the slot RAM from its home slot
// and gives its item; a write probes likewise, checks the prior writer and each
// recorded reader, records itself, then probes for each buffered read to record it
// throughput: one item at a time; a new item is taken only in the idle state
// reset and flush: a clearing pass over every entry of the slot RAM,
// during which no item is taken
// ----------------------------------------------------------------------------
module task_dependency_tracker_unit (
  input  logic clk,
  input  logic rst,
  tdt_in_if.sink    cmd,
  tdt_out_if.source res
);
  import tdt_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_HASH0  = 14'b00000000000100,
    S_HASH1  = 14'b00000000001000,
    S_PISSUE = 14'b00000000010000,
    S_PCHECK = 14'b00000000100000,
    S_RDEMIT = 14'b00000001000000,
    S_WAW    = 14'b00000010000000,
    S_RISSUE = 14'b00000100000000,
    S_RCHECK = 14'b00001000000000,
    S_WREC   = 14'b00010000000000,
    S_PEND   = 14'b00100000000000,
    S_FINAL  = 14'b01000000000000,
    S_FLUSH  = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_READ  = 3'b001,
    PH_WRITE = 3'b010,
    PH_PEND  = 3'b100
  } phase_t;

  state_t state;
  phase_t phase;

  logic [TASK_ID_BITS:0]   next_task;
  logic [PC_W-1:0]         pcount;
  logic [PC_W-1:0]         pidx;
  logic [ADDR_W-1:0]       pend [MAX_READS];
  logic [FC_W-1:0]         fcount;
  logic [TASK_ID_BITS-1:0] found [FOUND_CAP];
  logic [2:0]              err;
  logic [IDX_W-1:0]        clr_idx;

  logic [ADDR_W-1:0]       addr;
  logic [ADDR_W-1:0]       cur_addr;
  logic [IDX_W-1:0]        probe_idx;
  logic [IDX_W-1:0]        probe_cnt;
  logic [IDX_W-1:0]        sl;
  slot_t                   ent;
  logic                    hit;
  logic                    full;
  logic [RC_W-1:0]         rj;
  logic [TASK_ID_BITS-1:0] rd_pred;
  logic                    rd_dep;

  logic        out_valid;
  logic        out_load;
  logic [15:0] o_task, o_pred;
  logic        o_dep, o_last;
  logic [4:0]  o_total;
  logic [2:0]  o_status;

  logic [IDX_W-1:0]        home;
  slot_t                   slot_rd, slot_wd;
  logic                    slot_we;
  logic [IDX_W-1:0]        slot_wa;
  logic [TASK_ID_BITS-1:0] rd_rdata;
  logic                    rd_we;
  logic [TASK_ID_BITS-1:0] cand;
  logic                    cand_new;
  logic                    out_free;
  logic                    exhausted;
  logic [2:0]              err_ids, err_reads, err_full, err_ovf;
  logic                    key_hit;

  tdt_hash u_hash (.clk(clk), .addr(cur_addr), .slot(home));

  tdt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
    .raddr(probe_idx), .rdata(slot_rd)
  );

  tdt_ram #(.WIDTH(TASK_ID_BITS), .DEPTH(TABLE_ENTRIES * READERS_PER_ENTRY)) u_readers (
    .clk(clk), .we(rd_we), .waddr({sl, ent.rcount[RD_W-1:0]}), .wdata(next_task[TASK_ID_BITS-1:0]),
    .raddr({sl, rj[RD_W-1:0]}), .rdata(rd_rdata)
  );

  assign out_free  = !out_valid || res.ready;
  assign exhausted = next_task[TASK_ID_BITS];
  assign key_hit   = slot_rd.used && (slot_rd.key == cur_addr);

  // sticky error: first one raised in a task wins
  assign err_ids   = (err == ST_OK) ? ST_IDS   : err;
  assign err_reads = (err == ST_OK) ? ST_READS : err;
  assign err_full  = (err == ST_OK) ? ST_FULL  : err;
  assign err_ovf   = (err == ST_OK) ? ST_OVF   : err;

  // dependency dedupe against the task's found list
  always_comb begin
    if (state == S_RCHECK) begin
      cand = rd_rdata;
    end else if (state == S_WAW) begin
      cand = ent.wtask;
    end else begin
      cand = slot_rd.wtask;
    end
    cand_new = (fcount < FC_W'(FOUND_CAP));
    for (int i = 0; i < FOUND_CAP; i++) begin
      if ((FC_W'(i) < fcount) && (found[i] == cand)) cand_new = 1'b0;
    end
  end

  // a result item is loaded into the output register this cycle
  always_comb begin
    case (state)
      S_RDEMIT, S_FINAL, S_FLUSH: out_load = out_free;
      S_WAW:    out_load = out_free && hit && ent.wvalid && cand_new;
      S_RCHECK: out_load = out_free && cand_new;
      default:  out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    slot_we = 1'b0;
    slot_wa = sl;
    slot_wd = ent;
    rd_we   = 1'b0;
    case (state)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_idx;
        slot_wd = '0;
      end
      S_WREC: begin
        slot_we = !full;
        slot_wd = '{used: 1'b1, key: addr, wvalid: 1'b1,
                    wtask: next_task[TASK_ID_BITS-1:0], rcount: '0};
      end
      S_PEND: begin
        slot_we = !full && (ent.rcount < RC_W'(READERS_PER_ENTRY));
        rd_we   = slot_we;
        slot_wd = ent;
        slot_wd.rcount = ent.rcount + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      phase     <= PH_READ;
      clr_idx   <= '0;
      next_task <= '0;
      pcount    <= '0;
      fcount    <= '0;
      err       <= ST_OK;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.valid) begin
            addr     <= cmd.address;
            cur_addr <= cmd.address;
            case (cmd.opcode)
              OP_READ: begin
                phase   <= PH_READ;
                rd_pred <= '0;
                rd_dep  <= 1'b0;
                if (exhausted) begin
                  err   <= err_ids;
                  state <= S_RDEMIT;
                end else if (pcount >= PC_W'(MAX_READS)) begin
                  err   <= err_reads;
                  state <= S_RDEMIT;
                end else begin
                  pend[pcount[PI_W-1:0]] <= cmd.address;
                  pcount <= pcount + 1'b1;
                  state  <= S_HASH0;
                end
              end
              OP_WRITE: begin
                phase <= PH_WRITE;
                if (exhausted) begin
                  err   <= err_ids;
                  state <= S_FINAL;
                end else begin
                  state <= S_HASH0;
                end
              end
              OP_FLUSH: state <= S_FLUSH;
              default: ;
            endcase
          end
        end
        S_HASH0: state <= S_HASH1;
        S_HASH1: begin
          probe_idx <= home;
          probe_cnt <= '0;
          state     <= S_PISSUE;
        end
        S_PISSUE: state <= S_PCHECK;
        S_PCHECK: begin
          if (!slot_rd.used || key_hit || probe_cnt == '1) begin
            sl   <= probe_idx;
            hit  <= key_hit;
            full <= slot_rd.used && !key_hit;
            if (key_hit) begin
              ent <= slot_rd;
            end else begin
              ent <= '{used: 1'b1, key: cur_addr, wvalid: 1'b0, wtask: '0, rcount: '0};
            end
            case (phase)
              PH_READ: begin
                if (key_hit && slot_rd.wvalid) begin
                  rd_pred <= slot_rd.wtask;
                  rd_dep  <= cand_new;
                  if (cand_new) begin
                    found[fcount[FI_W-1:0]] <= cand;
                    fcount <= fcount + 1'b1;
                  end
                end
                state <= S_RDEMIT;
              end
              PH_WRITE: state <= S_WAW;
              PH_PEND:  state <= S_PEND;
              default:  state <= S_IDLE;
            endcase
          end else begin
            probe_idx <= probe_idx + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= S_PISSUE;
          end
        end
        S_RDEMIT: begin
          if (out_free) begin
            o_task    <= 16'(next_task);
            o_pred    <= 16'(rd_pred);
            o_dep     <= rd_dep;
            o_total   <= '0;
            o_status  <= err;
            o_last    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_WAW: begin
          if (!(hit && ent.wvalid && cand_new) || out_free) begin
            if (hit && ent.wvalid && cand_new) begin
              o_task    <= 16'(next_task);
              o_pred    <= 16'(ent.wtask);
              o_dep     <= 1'b1;
              o_total   <= '0;
              o_status  <= err;
              o_last    <= 1'b0;
              found[fcount[FI_W-1:0]] <= cand;
              fcount <= fcount + 1'b1;
            end
            rj    <= '0;
            state <= (hit && ent.rcount != '0) ? S_RISSUE : S_WREC;
          end
        end
        S_RISSUE: state <= S_RCHECK;
        S_RCHECK: begin
          if (!cand_new || out_free) begin
            if (cand_new) begin
              o_task    <= 16'(next_task);
              o_pred    <= 16'(rd_rdata);
              o_dep     <= 1'b1;
              o_total   <= '0;
              o_status  <= err;
              o_last    <= 1'b0;
              found[fcount[FI_W-1:0]] <= cand;
              fcount <= fcount + 1'b1;
            end
            rj    <= rj + 1'b1;
            state <= (RC_W'(rj + 1'b1) < ent.rcount) ? S_RISSUE : S_WREC;
          end
        end
        S_WREC: begin
          if (full) err <= err_full;
          pidx <= '0;
          if (pcount != '0) begin
            cur_addr <= pend[0];
            phase    <= PH_PEND;
            state    <= S_HASH0;
          end else begin
            state <= S_FINAL;
          end
        end
        S_PEND: begin
          if (full) begin
            err <= err_full;
          end else if (ent.rcount >= RC_W'(READERS_PER_ENTRY)) begin
            err <= err_ovf;
          end
          pidx <= pidx + 1'b1;
          if (PC_W'(pidx + 1'b1) < pcount) begin
            cur_addr <= pend[PI_W'(pidx + 1'b1)];
            state    <= S_HASH0;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            o_task    <= 16'(next_task);
            o_pred    <= '0;
            o_dep     <= 1'b0;
            o_total   <= 5'(fcount);
            o_status  <= err;
            o_last    <= 1'b1;
            if (!exhausted) next_task <= next_task + 1'b1;
            pcount <= '0;
            fcount <= '0;
            err    <= ST_OK;
            state  <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            o_task    <= '0;
            o_pred    <= '0;
            o_dep     <= 1'b0;
            o_total   <= '0;
            o_status  <= ST_OK;
            o_last    <= 1'b1;
            next_task <= '0;
            pcount    <= '0;
            fcount    <= '0;
            err       <= ST_OK;
            clr_idx   <= '0;
            state     <= S_CLEAR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready     = (state == S_IDLE);
  assign res.valid     = out_valid;
  assign res.task_id   = o_task;
  assign res.pred_task = o_pred;
  assign res.is_dep    = o_dep;
  assign res.dep_total = o_total;
  assign res.status    = o_status;
  assign res.last      = o_last;
endmodule

@@ bench/tb_task_dependency_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// tb_task_dependency_tracker_unit
// Self-checking bench for the task dependency tracker. A scoreboard keeps
// its own copy of the hazard table and predicts every dependency record.
// Directed tasks come first. Random task sequences over a small address pool
// follow. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_task_dependency_tracker_unit;
  import tdt_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct packed {
    logic [15:0] task_id;
    logic [15:0] pred_task;
    logic        is_dep;
    logic [4:0]  dep_total;
    logic [2:0]  status;
    logic        last;
  } dep_rec_t;

  class dep_scoreboard;
    int unsigned       mismatches;
    dep_rec_t          expected_recs[$];
    logic [16:0]       next_id;
    bit                used[TABLE_ENTRIES];
    logic [47:0]       key[TABLE_ENTRIES];
    bit                wvalid[TABLE_ENTRIES];
    logic [15:0]       wtask[TABLE_ENTRIES];
    int                rcount[TABLE_ENTRIES];
    logic [15:0]       rids[TABLE_ENTRIES][READERS_PER_ENTRY];
    logic [47:0]       pend[MAX_READS];
    int                npend;
    logic [15:0]       found[FOUND_CAP];
    int                nfound;
    logic [2:0]        err;

    function new();
      clear();
    endfunction

    function void clear();
      next_id = 0;
      foreach (used[i]) begin
        used[i] = 0;
        wvalid[i] = 0;
      end
      npend = 0;
      nfound = 0;
      err = ST_OK;
    endfunction

    function int home(logic [47:0] a);
      logic [63:0] h;
      h = {16'd0, a} >> 3;
      h ^= h >> 16;
      h = h * HASH_K;
      h ^= h >> 16;
      return int'(h[IDX_W-1:0]);
    endfunction

    function int find_slot(logic [47:0] a);
      int s;
      int idx;
      s = home(a);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        idx = (s + i) % TABLE_ENTRIES;
        if (!used[idx]) return -1;
        if (key[idx] == a) return idx;
      end
      return -1;
    endfunction

    function int take_slot(logic [47:0] a);
      int s;
      int idx;
      s = home(a);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        idx = (s + i) % TABLE_ENTRIES;
        if (!used[idx]) begin
          used[idx] = 1;
          key[idx] = a;
          wvalid[idx] = 0;
          wtask[idx] = 0;
          rcount[idx] = 0;
          return idx;
        end
        if (key[idx] == a) return idx;
      end
      return -1;
    endfunction

    function void raise(logic [2:0] code);
      if (err == ST_OK) err = code;
    endfunction

    function bit add_found(logic [15:0] p);
      for (int i = 0; i < nfound; i++)
        if (found[i] == p) return 0;
      if (nfound >= FOUND_CAP) return 0;
      found[nfound] = p;
      nfound++;
      return 1;
    endfunction

    function void push(logic [15:0] p, logic d, int total, logic l);
      dep_rec_t r;
      r.task_id = next_id[15:0];
      r.pred_task = p;
      r.is_dep = d;
      r.dep_total = total[4:0];
      r.status = err;
      r.last = l;
      expected_recs.push_back(r);
    endfunction

    function void end_task();
      npend = 0;
      nfound = 0;
      err = ST_OK;
    endfunction

    // work out the records that one accepted item causes
    function void note(logic [1:0] op, logic [47:0] a);
      bit exhausted;
      int s;
      int t;
      int n;
      logic [15:0] p;
      logic d;
      dep_rec_t r;
      exhausted = next_id[16];
      if (op == OP_FLUSH) begin
        clear();
        r = '0;
        r.last = 1;
        expected_recs.push_back(r);
      end else if (op == OP_READ) begin
        p = 0;
        d = 0;
        if (exhausted) raise(ST_IDS);
        else if (npend >= MAX_READS) raise(ST_READS);
        else begin
          pend[npend] = a;
          npend++;
          s = find_slot(a);
          if (s >= 0 && wvalid[s]) begin
            p = wtask[s];
            d = add_found(wtask[s]);
          end
        end
        push(p, d, 0, 0);
      end else if (op == OP_WRITE) begin
        if (exhausted) begin
          raise(ST_IDS);
          push(0, 0, nfound, 1);
          end_task();
        end else begin
          s = find_slot(a);
          if (s >= 0) begin
            if (wvalid[s] && add_found(wtask[s])) push(wtask[s], 1, 0, 0);
            n = rcount[s];
            for (int j = 0; j < n; j++)
              if (add_found(rids[s][j])) push(rids[s][j], 1, 0, 0);
          end
          s = take_slot(a);
          if (s < 0) raise(ST_FULL);
          else begin
            wvalid[s] = 1;
            wtask[s] = next_id[15:0];
            rcount[s] = 0;
          end
          for (int k = 0; k < npend; k++) begin
            t = take_slot(pend[k]);
            if (t < 0) raise(ST_FULL);
            else if (rcount[t] >= READERS_PER_ENTRY) raise(ST_OVF);
            else begin
              rids[t][rcount[t]] = next_id[15:0];
              rcount[t]++;
            end
          end
          push(0, 0, nfound, 1);
          next_id++;
          end_task();
        end
      end
      // unused opcode gives nothing
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s got %0h expected %0h", what, got, want);
      mismatches++;
    endtask

    task check(dep_rec_t got);
      dep_rec_t w;
      if (expected_recs.size() == 0) begin
        report("unexpected result, task_id", got.task_id, 0);
      end else begin
        w = expected_recs.pop_front();
        if (got.task_id !== w.task_id) report("task_id", got.task_id, w.task_id);
        if (got.pred_task !== w.pred_task) report("pred_task", got.pred_task, w.pred_task);
        if (got.is_dep !== w.is_dep) report("is_dep", got.is_dep, w.is_dep);
        if (got.dep_total !== w.dep_total) report("dep_total", got.dep_total, w.dep_total);
        if (got.status !== w.status) report("status", got.status, w.status);
        if (got.last !== w.last) report("last", got.last, w.last);
      end
    endtask
  endclass

  logic clk;
  logic rst;
  tdt_in_if  cmd();
  tdt_out_if res();

  task_dependency_tracker_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd.sink),
    .res (res.source)
  );

  dep_scoreboard sb;
  int unsigned   idle_cycles;
  logic [47:0]   pool[12];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at a falling edge
  task send_item(logic [1:0] op, logic [47:0] a);
    int g;
    g = pick_gap();
    if (g > 0) begin
      cmd.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.opcode <= op;
    cmd.address <= a;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sb.note(op, a);
    @(negedge clk);
  endtask

  task send_task(int nreads, logic [47:0] rd_addr, logic [47:0] wr_addr);
    for (int i = 0; i < nreads; i++) send_item(OP_READ, rd_addr);
    send_item(OP_WRITE, wr_addr);
  endtask

  function logic [47:0] rand_addr();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    return pool[$urandom_range(0, 11)];
  endfunction

  // result side stalls
  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      if (pick_gap() > 0) begin
        res.ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check({res.task_id, res.pred_task, res.is_dep, res.dep_total, res.status, res.last});
  end

  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("task_dependency_tracker_unit test failed");
      $finish;
    end
  end

  initial begin
    int nr;
    int r;
    logic [47:0] d_addr;
    sb = new();
    idle_cycles = 0;
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.opcode = OP_READ;
    cmd.address = '0;
    pool[0] = 48'h0;
    pool[1] = 48'hFFFF_FFFF_FFFF;
    pool[2] = 48'h1;
    pool[3] = 48'h8;
    for (int i = 4; i < 12; i++) pool[i] = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: own address, raw, waw and war, duplicate reads, extremes
    send_task(1, 48'h1000, 48'h1000);
    send_task(1, 48'h1000, 48'hFFFF_FFFF_FFFF);
    send_task(0, 48'h0, 48'h1000);
    send_task(2, 48'hFFFF_FFFF_FFFF, 48'h0);
    // too many reads, then a full reader list
    d_addr = 48'hAAAA_5555_0008;
    send_task(9, d_addr, 48'h5555_AAAA_FFF0);
    send_task(1, d_addr, 48'h5555_AAAA_FFF8);
    send_task(0, 48'h0, d_addr);
    send_item(OP_UNUSED, 48'h1234);
    send_item(OP_FLUSH, 48'h0);

    // random task sequences
    for (int n = 0; n < 230; ) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(OP_FLUSH, rand_addr());
        n++;
      end else if (r < 8) begin
        send_item(OP_UNUSED, rand_addr());
        n++;
      end else begin
        nr = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        for (int i = 0; i < nr; i++) send_item(OP_READ, rand_addr());
        send_item(OP_WRITE, rand_addr());
        n += nr + 1;
      end
    end
    cmd.valid <= 1'b0;

    while (sb.expected_recs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("task_dependency_tracker_unit test passed");
    end else begin
      $display("task_dependency_tracker_unit test failed");
    end
    $finish;
  end

endmodule
